[rtl/sql_response_packet_classifier_assert.svh]
// Assertion macros used by the checker file of the response packet classifier.
`ifndef SQL_RESPONSE_PACKET_CLASSIFIER_ASSERT_SVH
`define SQL_RESPONSE_PACKET_CLASSIFIER_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define SRPC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define SRPC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

[rtl/srpc_pkg.sv]
// Shared types and constants of the response packet classifier.
`default_nettype none

package srpc_pkg;

    // Byte counter width; the count saturates at its top value
    localparam int CNT_W = 5;

    // Header codes
    localparam logic [7:0] HDR_OK  = 8'h00;
    localparam logic [7:0] HDR_EOF = 8'hfe;
    localparam logic [7:0] HDR_ERR = 8'hff;

    // Length-encoded integer prefixes
    localparam logic [7:0] LENC_2B     = 8'hfc;
    localparam logic [7:0] LENC_3B     = 8'hfd;
    localparam logic [7:0] LENC_8B     = 8'hfe;
    localparam logic [7:0] LENC_MAX_1B = 8'd251;

    // Bit of the more-results flag in a status byte
    localparam int MORE_BIT = 3;

    // Byte positions and packet lengths
    localparam logic [CNT_W-1:0] COUNT_MAX       = 5'd31;
    localparam logic [CNT_W-1:0] POS_EOF_STATUS  = 5'd3;
    localparam logic [CNT_W-1:0] POS_NINTH       = 5'd9;
    localparam logic [CNT_W-1:0] LEN_EOF_V41     = 5'd5;
    localparam logic [CNT_W-1:0] LEN_EOF_OLD     = 5'd1;
    localparam logic [CNT_W-1:0] LEN_OK_V41_MIN  = 5'd7;
    localparam logic [CNT_W-1:0] LEN_OK_OLD_MIN  = 5'd3;
    localparam logic [CNT_W-1:0] LEN_SHORT_LIM   = 5'd9;
    localparam logic [CNT_W-1:0] LEN_ERR_ABOVE   = 5'd3;
    localparam logic [CNT_W-1:0] LEN_LENC_8B     = 5'd9;
    localparam logic [CNT_W-1:0] LEN_LENC_3B     = 5'd4;
    localparam logic [CNT_W-1:0] LEN_LENC_2B     = 5'd3;
    localparam logic [CNT_W-1:0] LEN_LENC_1B     = 5'd1;
    localparam logic [CNT_W-1:0] LEN_PREPARE     = 5'd12;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Parser phase after an OK header
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_STATUS,
        PH_DONE
    } lenc_phase_t;

    // Per-packet classification handed from front to back
    typedef struct packed {
        logic eof_v41;
        logic eof_old;
        logic ok_v41;
        logic ok_old;
        logic err;
        logic lenc_int;
        logic prepare_ok;
        logic more;
    } cls_rec_t;

endpackage

`default_nettype wire

[rtl/srpc_front.sv]
// Front part: per-byte packet state, parser and classification on the last byte.
`default_nettype none

module srpc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    output logic               push,
    output srpc_pkg::cls_rec_t push_rec
);
    import srpc_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       hdr_reg, hdr_next;
    logic [7:0]       third_reg, third_next;
    logic [7:0]       ninth_reg, ninth_next;
    lenc_phase_t      phase_reg, phase_next;
    logic [3:0]       rem_reg, rem_next;
    logic [7:0]       status_reg, status_next;
    logic             seen_reg, seen_next;
    logic             parse_step;
    logic             eof_any;

    // Value bytes that follow a length-encoded prefix
    function automatic logic [3:0] lenc_skip(input logic [7:0] b);
        logic [3:0] r;
        case (b)
            LENC_2B: r = 4'd2;
            LENC_3B: r = 4'd3;
            LENC_8B: r = 4'd8;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // Parser runs on every byte after the header; it advances once no skip is pending
    assign parse_step = (count_reg != '0) && (rem_reg == '0);

    // Parser next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (parse_step)
        begin
            case (phase_reg)
                PH_FIRST:  phase_next = PH_SECOND;
                PH_SECOND: phase_next = PH_STATUS;
                PH_STATUS: phase_next = PH_DONE;
                PH_DONE:   phase_next = PH_DONE;
                default:   phase_next = PH_FIRST;
            endcase
        end
    end

    // Parser actions: skip count and status capture
    always_comb
    begin
        rem_next    = rem_reg;
        status_next = status_reg;
        seen_next   = seen_reg;
        if (count_reg != '0)
        begin
            if (rem_reg != '0)
            begin
                rem_next = rem_reg - 4'd1;
            end
            else if (phase_reg inside {PH_FIRST, PH_SECOND})
            begin
                rem_next = lenc_skip(data_byte);
            end
            else if (phase_reg == PH_STATUS)
            begin
                status_next = data_byte;
                seen_next   = 1'b1;
            end
        end
    end

    // Captured bytes and saturating length
    always_comb
    begin
        hdr_next   = (count_reg == '0) ? data_byte : hdr_reg;
        third_next = (count_reg == POS_EOF_STATUS) ? data_byte : third_reg;
        ninth_next = (count_reg == POS_NINTH) ? data_byte : ninth_reg;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // Classification from the state including the current byte
    always_comb
    begin
        push_rec.eof_v41 = (hdr_next == HDR_EOF) && (count_next == LEN_EOF_V41);
        push_rec.eof_old = (hdr_next == HDR_EOF) && (count_next == LEN_EOF_OLD);
        eof_any          = push_rec.eof_v41 || push_rec.eof_old;
        push_rec.ok_v41  = ((hdr_next == HDR_OK) && (count_next >= LEN_OK_V41_MIN))
                        || ((hdr_next == HDR_EOF) && (count_next < LEN_SHORT_LIM) && !eof_any);
        push_rec.ok_old  = (hdr_next == HDR_OK) && (count_next >= LEN_OK_OLD_MIN);
        push_rec.err     = (hdr_next == HDR_ERR) && (count_next > LEN_ERR_ABOVE);
        case (hdr_next)
            LENC_8B: push_rec.lenc_int = (count_next == LEN_LENC_8B);
            LENC_3B: push_rec.lenc_int = (count_next == LEN_LENC_3B);
            LENC_2B: push_rec.lenc_int = (count_next == LEN_LENC_2B);
            default: push_rec.lenc_int = (count_next == LEN_LENC_1B)
                                      && (hdr_next < LENC_MAX_1B);
        endcase
        push_rec.prepare_ok = (count_next == LEN_PREPARE) && (hdr_next == HDR_OK)
                           && (ninth_next == 8'h00);
        if (push_rec.ok_v41)
            push_rec.more = seen_next && status_next[MORE_BIT];
        else if (push_rec.eof_v41)
            push_rec.more = third_next[MORE_BIT];
        else
            push_rec.more = 1'b0;
    end

    assign push = accept && last_byte;

    // Packet state; cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            hdr_reg    <= '0;
            third_reg  <= '0;
            ninth_reg  <= '0;
            phase_reg  <= PH_FIRST;
            rem_reg    <= '0;
            status_reg <= '0;
            seen_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                count_reg  <= '0;
                hdr_reg    <= '0;
                third_reg  <= '0;
                ninth_reg  <= '0;
                phase_reg  <= PH_FIRST;
                rem_reg    <= '0;
                status_reg <= '0;
                seen_reg   <= 1'b0;
            end
            else
            begin
                count_reg  <= count_next;
                hdr_reg    <= hdr_next;
                third_reg  <= third_next;
                ninth_reg  <= ninth_next;
                phase_reg  <= phase_next;
                rem_reg    <= rem_next;
                status_reg <= status_next;
                seen_reg   <= seen_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/srpc_queue.sv]
// Short queue of classification records between front and back.
`default_nettype none

module srpc_queue #(
    parameter int DEPTH = srpc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  srpc_pkg::cls_rec_t push_rec,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output srpc_pkg::cls_rec_t head_rec
);
    import srpc_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(DEPTH);

    cls_rec_t           slot_reg [DEPTH];
    logic [IDX_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0]  cnt_reg;
    logic               do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_rec  = slot_reg[rd_ptr_reg];

    // Record storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

[rtl/srpc_back.sv]
// Back part: mode register, final flags and the output register.
`default_nettype none

module srpc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               rec_valid,
    input  srpc_pkg::cls_rec_t rec,
    output logic               pop,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               is_eof_v41,
    output logic               is_eof_old,
    output logic               is_ok_v41,
    output logic               is_ok_old,
    output logic               is_err,
    output logic               is_lenc_int,
    output logic               is_column_def,
    output logic               is_resultset_row,
    output logic               is_prepare_ok,
    output logic               more_results
);
    import srpc_pkg::*;

    logic     deprecate_eof_reg;
    logic     valid_reg;
    cls_rec_t rec_reg;
    logic     coldef_reg, row_reg;
    logic     eof_any, ok_any;
    logic     coldef_next, row_next;

    // Take a record when the output register is free or being emptied
    assign pop = rec_valid && (!valid_reg || !out_stall);

    // Flags that depend on the whole class set and on the mode
    always_comb
    begin
        eof_any     = rec.eof_v41 || rec.eof_old;
        ok_any      = rec.ok_v41 || rec.ok_old;
        coldef_next = !(eof_any || ok_any || rec.err);
        row_next    = (deprecate_eof_reg ? !ok_any : !eof_any) && !rec.err;
    end

    // Mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deprecate_eof_reg <= 1'b0;
        else if (cfg_we)
            deprecate_eof_reg <= cfg_data;
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pop)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            rec_reg    <= rec;
            coldef_reg <= coldef_next;
            row_reg    <= row_next;
        end
    end

    assign out_valid        = valid_reg;
    assign is_eof_v41       = rec_reg.eof_v41;
    assign is_eof_old       = rec_reg.eof_old;
    assign is_ok_v41        = rec_reg.ok_v41;
    assign is_ok_old        = rec_reg.ok_old;
    assign is_err           = rec_reg.err;
    assign is_lenc_int      = rec_reg.lenc_int;
    assign is_column_def    = coldef_reg;
    assign is_resultset_row = row_reg;
    assign is_prepare_ok    = rec_reg.prepare_ok;
    assign more_results     = rec_reg.more;

endmodule

`default_nettype wire

[rtl/sql_response_packet_classifier.sv]
// Top level of the SQL response packet classifier.
//
//  Channel   Handshake              Payload
//  -------   ---------------------  -------------------------------------------
//  in        in_valid / in_stall    data_byte, last_byte
//  out       out_valid / out_stall  is_eof_v41 ... more_results (10 flags)
//  cfg       cfg_valid / cfg_ready  eof_deprecated
//
//  One byte is taken every cycle while in_stall is low; a byte with last_byte set
//  produces one result. The edge that takes its last byte writes the record into
//  the queue; the output register loads it from there once free or being emptied.
//  in_stall rises only when the record queue is full, i.e. after out_stall has
//  held back the output register long enough. cfg_ready is always high.
//  Reset clears the packet state, the queue and the mode bit; no clearing pass.
`default_nettype none

module sql_response_packet_classifier #(
    parameter int QUEUE_DEPTH = srpc_pkg::QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       eof_deprecated,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       is_eof_v41,
    output logic       is_eof_old,
    output logic       is_ok_v41,
    output logic       is_ok_old,
    output logic       is_err,
    output logic       is_lenc_int,
    output logic       is_column_def,
    output logic       is_resultset_row,
    output logic       is_prepare_ok,
    output logic       more_results
);
    import srpc_pkg::*;

    logic     in_accept;
    logic     push, pop;
    logic     q_full, q_not_empty;
    cls_rec_t push_rec, head_rec;

    assign in_stall  = q_full;
    assign in_accept = in_valid && !q_full;
    assign cfg_ready = 1'b1;

    srpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .push_rec  (push_rec)
    );

    srpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    srpc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_valid && cfg_ready),
        .cfg_data         (eof_deprecated),
        .rec_valid        (q_not_empty),
        .rec              (head_rec),
        .pop              (pop),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .is_eof_v41       (is_eof_v41),
        .is_eof_old       (is_eof_old),
        .is_ok_v41        (is_ok_v41),
        .is_ok_old        (is_ok_old),
        .is_err           (is_err),
        .is_lenc_int      (is_lenc_int),
        .is_column_def    (is_column_def),
        .is_resultset_row (is_resultset_row),
        .is_prepare_ok    (is_prepare_ok),
        .more_results     (more_results)
    );

endmodule

`default_nettype wire

[rtl/srpc_checker.sv]
// Port-level checks of the response packet classifier, bound to the top level.
`default_nettype none

`include "sql_response_packet_classifier_assert.svh"

module srpc_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_stall,
    input logic is_eof_v41,
    input logic is_eof_old,
    input logic is_ok_v41,
    input logic is_ok_old,
    input logic is_err,
    input logic is_lenc_int,
    input logic is_column_def,
    input logic is_resultset_row,
    input logic is_prepare_ok,
    input logic more_results
);

    logic any_class;
    logic coldef_bad;
    logic prep_bad;
    logic more_bad;
    logic lenc_bad;

    // Flag combinations that a valid result never shows
    assign any_class  = is_eof_v41 || is_eof_old || is_ok_v41 || is_ok_old || is_err;
    assign coldef_bad = (is_column_def == any_class);
    assign prep_bad   = is_prepare_ok && !(is_ok_v41 && is_ok_old);
    assign more_bad   = more_results && !is_ok_v41 && !is_eof_v41;
    assign lenc_bad   = is_lenc_int && !(is_column_def && is_resultset_row);

    // A held result stays offered
    `SRPC_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "dropped while stalled")

    // Column definition means no other terminator class
    `SRPC_ASSERT_NEVER(a_coldef, clk, rst_n, out_valid && coldef_bad, "bad column definition flag")

    // A prepare OK is an OK in both forms
    `SRPC_ASSERT_NEVER(a_prepare, clk, rst_n, out_valid && prep_bad, "prepare OK not an OK")

    // More-results only comes from a 4.1 OK or 4.1 EOF
    `SRPC_ASSERT_NEVER(a_more_src, clk, rst_n, out_valid && more_bad, "stray more_results")

    // A bare integer packet is a column definition and a row
    `SRPC_ASSERT_NEVER(a_lenc, clk, rst_n, out_valid && lenc_bad, "integer packet not a row")

endmodule

bind sql_response_packet_classifier srpc_checker u_srpc_checker (.*);

`default_nettype wire

[verif/srpc_result_checker.sv]
// Result checker for the response packet classifier: predicts each classification and compares it.
`timescale 1ns / 1ps

module srpc_result_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic       eof_deprecated,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic       is_eof_v41,
    input  logic       is_eof_old,
    input  logic       is_ok_v41,
    input  logic       is_ok_old,
    input  logic       is_err,
    input  logic       is_lenc_int,
    input  logic       is_column_def,
    input  logic       is_resultset_row,
    input  logic       is_prepare_ok,
    input  logic       more_results,
    output int         fail_count,
    output int         pending
);
    import srpc_pkg::*;

    localparam int FLAG_COUNT   = 10;
    localparam int REPORT_LIMIT = 10;

    // One packet classification, flags in port order
    typedef struct packed {
        logic eof_v41;
        logic eof_old;
        logic ok_v41;
        logic ok_old;
        logic err;
        logic lenc_int;
        logic column_def;
        logic resultset_row;
        logic prepare_ok;
        logic more;
    } pkt_class_t;

    // Mode bit and per-packet state of the predictor
    logic             rows_end_ok;
    logic [CNT_W-1:0] seen_cnt;
    logic [7:0]       hdr;
    logic [7:0]       pos3_byte;
    logic [7:0]       pos9_byte;
    lenc_phase_t      phase;
    logic [3:0]       skip_left;
    logic [7:0]       status_cap;
    logic             status_got;

    pkt_class_t       class_q[$];
    int               mismatches;
    int               results_seen;

    function automatic string flag_name(input int i);
        case (i)
            9: return "is_eof_v41";
            8: return "is_eof_old";
            7: return "is_ok_v41";
            6: return "is_ok_old";
            5: return "is_err";
            4: return "is_lenc_int";
            3: return "is_column_def";
            2: return "is_resultset_row";
            1: return "is_prepare_ok";
            default: return "more_results";
        endcase
    endfunction

    function automatic string diff_names(input logic [FLAG_COUNT-1:0] diff);
        string s = "";
        for (int i = FLAG_COUNT - 1; i >= 0; i--)
            if (diff[i])
                s = {s, " ", flag_name(i)};
        return s;
    endfunction

    task automatic clear_packet_state();
        seen_cnt   = '0;
        hdr        = '0;
        pos3_byte  = '0;
        pos9_byte  = '0;
        phase      = PH_FIRST;
        skip_left  = '0;
        status_cap = '0;
        status_got = 1'b0;
    endtask

    // Take one payload byte; on the last byte queue the predicted classification
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic       eof41;
        logic       eofold;
        logic       ok41;
        logic       okold;
        logic       errp;
        logic       lenc;
        pkt_class_t c;

        // header capture, else the length-encoded integer walker
        if (seen_cnt == '0)
            hdr = b;
        else if (skip_left != '0)
            skip_left = skip_left - 4'd1;
        else if (phase == PH_FIRST || phase == PH_SECOND)
        begin
            case (b)
                LENC_2B: skip_left = 4'd2;
                LENC_3B: skip_left = 4'd3;
                LENC_8B: skip_left = 4'd8;
                default: skip_left = 4'd0;
            endcase
            phase = (phase == PH_FIRST) ? PH_SECOND : PH_STATUS;
        end
        else if (phase == PH_STATUS)
        begin
            status_cap = b;
            status_got = 1'b1;
            phase      = PH_DONE;
        end

        if (seen_cnt == POS_EOF_STATUS)
            pos3_byte = b;
        if (seen_cnt == POS_NINTH)
            pos9_byte = b;
        if (seen_cnt != COUNT_MAX)
            seen_cnt = seen_cnt + 1'b1;

        if (fin)
        begin
            eof41  = (hdr == HDR_EOF) && (seen_cnt == LEN_EOF_V41);
            eofold = (hdr == HDR_EOF) && (seen_cnt == LEN_EOF_OLD);
            ok41   = ((hdr == HDR_OK) && (seen_cnt >= LEN_OK_V41_MIN)) ||
                     ((hdr == HDR_EOF) && (seen_cnt < LEN_SHORT_LIM) && !(eof41 || eofold));
            okold  = (hdr == HDR_OK) && (seen_cnt >= LEN_OK_OLD_MIN);
            errp   = (hdr == HDR_ERR) && (seen_cnt > LEN_ERR_ABOVE);
            case (hdr)
                LENC_8B: lenc = (seen_cnt == LEN_LENC_8B);
                LENC_3B: lenc = (seen_cnt == LEN_LENC_3B);
                LENC_2B: lenc = (seen_cnt == LEN_LENC_2B);
                default: lenc = (seen_cnt == LEN_LENC_1B) && (hdr < LENC_MAX_1B);
            endcase

            c.eof_v41       = eof41;
            c.eof_old       = eofold;
            c.ok_v41        = ok41;
            c.ok_old        = okold;
            c.err           = errp;
            c.lenc_int      = lenc;
            c.column_def    = !(eof41 || eofold || ok41 || okold || errp);
            c.resultset_row = (rows_end_ok ? !(ok41 || okold) : !(eof41 || eofold)) && !errp;
            c.prepare_ok    = (seen_cnt == LEN_PREPARE) && (hdr == HDR_OK) &&
                              (pos9_byte == 8'h00);
            // overrun of the two integers leaves the status unseen
            if (ok41)
                c.more = status_got && status_cap[MORE_BIT];
            else if (eof41)
                c.more = pos3_byte[MORE_BIT];
            else
                c.more = 1'b0;

            class_q.push_back(c);
            clear_packet_state();
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        pkt_class_t got;
        pkt_class_t want;

        if (!rst_n)
        begin
            rows_end_ok = 1'b0;
            clear_packet_state();
            class_q.delete();
            mismatches   = 0;
            results_seen = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rows_end_ok = eof_deprecated;

            // compare the result transaction before queuing a new expectation
            if (out_valid && !out_stall)
            begin
                got = {is_eof_v41, is_eof_old, is_ok_v41, is_ok_old, is_err, is_lenc_int,
                       is_column_def, is_resultset_row, is_prepare_ok, more_results};
                if (class_q.size() == 0)
                begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result %0d arrived with none expected, got %b",
                                 $time, results_seen, got);
                    mismatches++;
                end
                else
                begin
                    want = class_q.pop_front();
                    if (got != want)
                    begin
                        if (mismatches < REPORT_LIMIT)
                            $display("%0t: result %0d expected %b got %b, wrong:%s",
                                     $time, results_seen, want, got, diff_names(want ^ got));
                        mismatches++;
                    end
                end
                results_seen++;
            end

            if (in_valid && !in_stall)
                absorb_byte(data_byte, last_byte);

            fail_count <= mismatches;
            pending    <= class_q.size();
        end
    end

endmodule

[verif/sql_response_packet_classifier_tb.sv]
// Testbench top for the response packet classifier: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sql_response_packet_classifier_tb;
    import srpc_pkg::*;

    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BYTES   = 100;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       eof_deprecated;
    logic       out_valid;
    logic       out_stall;
    logic       is_eof_v41;
    logic       is_eof_old;
    logic       is_ok_v41;
    logic       is_ok_old;
    logic       is_err;
    logic       is_lenc_int;
    logic       is_column_def;
    logic       is_resultset_row;
    logic       is_prepare_ok;
    logic       more_results;

    int         fail_count;
    int         pending;
    int         hold_req   = 0;
    int         holds_done = 0;
    int         bytes_sent = 0;
    logic [7:0] pkt[$];

    always #5 clk = ~clk;

    sql_response_packet_classifier DUT (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .eof_deprecated      (eof_deprecated),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .is_eof_v41          (is_eof_v41),
        .is_eof_old          (is_eof_old),
        .is_ok_v41           (is_ok_v41),
        .is_ok_old           (is_ok_old),
        .is_err              (is_err),
        .is_lenc_int         (is_lenc_int),
        .is_column_def       (is_column_def),
        .is_resultset_row    (is_resultset_row),
        .is_prepare_ok       (is_prepare_ok),
        .more_results        (more_results)
    );

    srpc_result_checker result_check (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .data_byte           (data_byte),
        .last_byte           (last_byte),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .eof_deprecated      (eof_deprecated),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .is_eof_v41          (is_eof_v41),
        .is_eof_old          (is_eof_old),
        .is_ok_v41           (is_ok_v41),
        .is_ok_old           (is_ok_old),
        .is_err              (is_err),
        .is_lenc_int         (is_lenc_int),
        .is_column_def       (is_column_def),
        .is_resultset_row    (is_resultset_row),
        .is_prepare_ok       (is_prepare_ok),
        .more_results        (more_results),
        .fail_count          (fail_count),
        .pending             (pending)
    );

    // Sender gap: mostly none, some short, a few long
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // One byte transaction; valid is left high for the next byte
    task automatic send_byte(input logic [7:0] b, input logic fin, input bit calm);
        int gap;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        bit calm;
        calm = ($urandom_range(0, 3) == 0);
        foreach (pkt[i])
            send_byte(pkt[i], i == pkt.size() - 1, calm);
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(input logic v);
        cfg_valid      <= 1'b1;
        eof_deprecated <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic push_rand(input int count);
        repeat (count) pkt.push_back(8'($urandom_range(0, 255)));
    endtask

    // One length-encoded integer of random form
    task automatic push_lenc();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            pkt.push_back(8'($urandom_range(0, 250)));
        else if (r == 5)
            pkt.push_back($urandom_range(0, 1) ? 8'hfb : 8'hff);
        else if (r == 6)
        begin
            pkt.push_back(LENC_2B);
            push_rand(2);
        end
        else if (r == 7)
        begin
            pkt.push_back(LENC_3B);
            push_rand(3);
        end
        else
        begin
            pkt.push_back(LENC_8B);
            push_rand(8);
        end
    endtask

    // Random packet, mostly well-formed responses with random content
    task automatic gen_packet();
        int r;
        int keep;
        pkt.delete();
        r = $urandom_range(0, 99);
        if (r < 15)
        begin
            pkt.push_back(HDR_EOF);
            push_rand(4);
        end
        else if (r < 20)
            pkt.push_back(HDR_EOF);
        else if (r < 40)
        begin
            // OK: two integers, status, trailing bytes; sometimes cut short
            pkt.push_back(HDR_OK);
            push_lenc();
            push_lenc();
            push_rand($urandom_range(1, 4));
            if ($urandom_range(0, 4) == 0)
            begin
                keep = $urandom_range(1, pkt.size());
                while (pkt.size() > keep) void'(pkt.pop_back());
            end
        end
        else if (r < 45)
        begin
            pkt.push_back(HDR_EOF);
            push_rand($urandom_range(1, 10));
        end
        else if (r < 55)
        begin
            pkt.push_back(HDR_ERR);
            push_rand($urandom_range(1, 10));
        end
        else if (r < 65)
            push_lenc();
        else if (r < 70)
        begin
            pkt.push_back(HDR_OK);
            push_rand(11);
            if ($urandom_range(0, 9) < 7)
                pkt[9] = 8'h00;
        end
        else if (r < 97)
            push_rand($urandom_range(1, 14));
        else
            push_rand($urandom_range(20, 40));
    endtask

    task automatic random_phase(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            gen_packet();
            send_packet();
        end
    endtask

    // Receiver: random stalls, calm stretches, and long hold-offs on request
    initial
    begin : receiver
        int r;
        int run;
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_done != hold_req)
            begin
                holds_done <= holds_done + 1;
                out_stall  <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 15)
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(50, 150);
                end
                else if (r < 60)
                begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 4);
                end
                else if (r < 95)
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end
                else
                begin
                    out_stall <= 1'b1;
                    run = $urandom_range(10, 40);
                end
                repeat (run) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        last_byte      = 1'b0;
        cfg_valid      = 1'b0;
        eof_deprecated = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every packet form, rows ending with EOF
        write_mode(1'b0);
        pkt = '{HDR_EOF};
        send_packet();
        pkt = '{HDR_EOF, 8'h00, 8'h00, 8'h08, 8'h00};
        send_packet();
        pkt = '{HDR_OK, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00};
        send_packet();
        pkt = '{HDR_OK, 8'h00, 8'h00};
        send_packet();
        pkt = '{HDR_OK, LENC_2B, 8'h01, 8'h02, LENC_3B, 8'h01, 8'h02, 8'h03, 8'h08, 8'h00};
        send_packet();
        // second integer runs past the end
        pkt = '{HDR_OK, LENC_8B, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08,
                LENC_8B, 8'h01};
        send_packet();
        pkt = '{HDR_ERR, 8'hff, 8'hff, 8'hff};
        send_packet();
        pkt = '{HDR_ERR, 8'h01, 8'h02};
        send_packet();
        pkt = '{LENC_2B, 8'h01, 8'h02};
        send_packet();
        pkt = '{LENC_3B, 8'h01, 8'h02, 8'h03};
        send_packet();
        pkt = '{LENC_8B, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08};
        send_packet();
        pkt = '{8'hfa};
        send_packet();
        pkt = '{8'hfb};
        send_packet();
        pkt = '{HDR_ERR};
        send_packet();
        // EOF header on a short OK packet
        pkt = '{HDR_EOF, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00};
        send_packet();
        pkt = '{HDR_OK, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h00,
                8'h0a, 8'h0b};
        send_packet();
        pkt = '{HDR_OK, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
                8'h0a, 8'h0b};
        send_packet();
        // long packet saturates the byte count
        pkt.delete();
        push_rand(35);
        send_packet();
        drain();

        // Rows ending with OK; long receiver hold-off while the sender keeps going
        write_mode(1'b1);
        hold_req <= hold_req + 1;
        @(posedge clk);
        while (holds_done != hold_req) @(posedge clk);
        repeat (12) send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        random_phase(PHASE_BYTES);
        drain();

        write_mode(1'b0);
        random_phase(PHASE_BYTES);
        drain();

        write_mode(1'b1);
        random_phase(PHASE_BYTES);
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
